/* design/srgbcr_pkg.sv */
// ---------------------------------------------------------------------------
// srgbcr_pkg: shared constants, types and decode table
// Widths, luminance weights, the sRGB decode table built at elaboration, and
// the payload passed from the luminance stages to the divider.
// ---------------------------------------------------------------------------
package srgbcr_pkg;

  localparam int ChannelBits = 8;
  localparam int FracBits    = 16;
  localparam int LinBits     = FracBits + 1;
  localparam int CodeCount   = 1 << ChannelBits;
  localparam int WeightBits  = 13;
  localparam int ProdBits    = 30;
  localparam int SumBits     = 30;
  localparam int OutBits     = 5 + FracBits;
  localparam int QuotBits    = OutBits;
  localparam int HeadBits    = QuotBits - FracBits;

  localparam logic [WeightBits-1:0] WeightRed   = 13'd2126;
  localparam logic [WeightBits-1:0] WeightGreen = 13'd7152;
  localparam logic [WeightBits-1:0] WeightBlue  = 13'd722;

  localparam logic [SumBits-1:0] LumaOffset = SumBits'(64'd500 << FracBits);
  localparam logic [OutBits-1:0] MaxRatio   = OutBits'(64'd21 << FracBits);

  typedef logic [LinBits-1:0] lin_t;
  typedef lin_t lut_t [CodeCount];
  typedef logic [SumBits-1:0] sum_t;

  typedef struct packed {
    sum_t num;
    sum_t den;
  } ratio_req_t;

  // Shift-subtract division, used only while the table is built.
  function automatic logic [63:0] long_div(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] q31_mul(logic [63:0] p, logic [63:0] q);
    logic [63:0] prod;
    prod = p * q;
    return prod >> 31;
  endfunction

  function automatic logic [63:0] fifth_power(logic [63:0] u);
    logic [63:0] w;
    logic [63:0] p;
    w = u << (30 - FracBits);
    p = q31_mul(w, w);
    p = q31_mul(p, w);
    p = q31_mul(p, w);
    return q31_mul(p, w);
  endfunction

  function automatic logic [63:0] srgb_decode(logic [63:0] c);
    logic [63:0] full;
    logic [63:0] den;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] y4;
    logic [63:0] y8;
    logic [63:0] z;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    full = 64'(CodeCount - 1);
    if (100000 * c < 4045 * full) begin
      den = 1292 * full;
      return long_div(((100 * c) << (FracBits + 1)) + den, 2 * den);
    end
    a = 200 * c + 11 * full;
    b = 211 * full;
    y = long_div(a << 31, b);
    if (y > (64'd1 << 31)) begin
      y = 64'd1 << 31;
    end
    y2 = q31_mul(y, y);
    y4 = q31_mul(y2, y2);
    y8 = q31_mul(y4, y4);
    z  = q31_mul(y8, y4);
    lo = '0;
    hi = 64'd1 << (FracBits + 1);
    for (int i = 0; i < 64; i++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (fifth_power(mid) <= z) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return (lo + 1) >> 1;
  endfunction

  function automatic lut_t build_lut();
    lut_t t;
    for (int i = 0; i < CodeCount; i++) begin
      t[i] = LinBits'(srgb_decode(64'(i)));
    end
    return t;
  endfunction

  localparam lut_t DecodeLut = build_lut();

endpackage

/* design/srgbcr_luma.sv */
// ---------------------------------------------------------------------------
// srgbcr_luma: decode and luminance stages
// Three stages: table decode of six channels, weight multiply, and the two
// offset luminance sums that form numerator and divisor.
// ---------------------------------------------------------------------------
module srgbcr_luma (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              first_red_i,
  input  logic [7:0]              first_green_i,
  input  logic [7:0]              first_blue_i,
  input  logic [7:0]              second_red_i,
  input  logic [7:0]              second_green_i,
  input  logic [7:0]              second_blue_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output srgbcr_pkg::ratio_req_t  out_req_o
);
  import srgbcr_pkg::*;

  localparam int Stages = 3;

  logic [ChannelBits-1:0] code [6];
  logic [WeightBits-1:0]  weight [6];
  logic                   vld_q [Stages];
  logic                   rdy [Stages+1];
  lin_t                   lin_q [6];
  logic [ProdBits-1:0]    prod_q [6];
  sum_t                   num_q;
  sum_t                   den_q;

  assign code[0] = first_red_i;
  assign code[1] = first_green_i;
  assign code[2] = first_blue_i;
  assign code[3] = second_red_i;
  assign code[4] = second_green_i;
  assign code[5] = second_blue_i;

  assign weight[0] = WeightRed;
  assign weight[1] = WeightGreen;
  assign weight[2] = WeightBlue;
  assign weight[3] = WeightRed;
  assign weight[4] = WeightGreen;
  assign weight[5] = WeightBlue;

  // A stage takes a new item when it is empty or its item moves on.
  always_comb begin
    rdy[Stages] = out_ready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Stages; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      for (int i = 0; i < 6; i++) begin
        lin_q[i] <= DecodeLut[code[i]];
      end
    end
    if (rdy[1] && vld_q[0]) begin
      for (int i = 0; i < 6; i++) begin
        prod_q[i] <= ProdBits'(lin_q[i]) * ProdBits'(weight[i]);
      end
    end
    if (rdy[2] && vld_q[1]) begin
      num_q <= prod_q[0] + prod_q[1] + prod_q[2] + LumaOffset;
      den_q <= prod_q[3] + prod_q[4] + prod_q[5] + LumaOffset;
    end
  end

  assign out_valid_o   = vld_q[Stages-1];
  assign out_req_o.num = num_q;
  assign out_req_o.den = den_q;

endmodule

/* design/srgbcr_divider.sv */
// ---------------------------------------------------------------------------
// srgbcr_divider: pipelined restoring divider
// One quotient bit per stage; the integer head of the numerator seeds the
// remainder, then numerator low bits and fraction zeros shift in.
// ---------------------------------------------------------------------------
module srgbcr_divider (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  srgbcr_pkg::ratio_req_t  in_req_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [srgbcr_pkg::QuotBits-1:0] quot_o
);
  import srgbcr_pkg::*;

  localparam int Depth = QuotBits;

  logic                vld_q [Depth];
  logic                rdy [Depth+1];
  sum_t                rem_q [Depth];
  sum_t                den_q [Depth];
  logic [QuotBits-1:0] rest_q [Depth];
  logic [QuotBits-1:0] quot_q [Depth];

  logic                vld_in [Depth];
  sum_t                rem_in [Depth];
  sum_t                den_in [Depth];
  logic [QuotBits-1:0] rest_in [Depth];
  logic [QuotBits-1:0] quot_in [Depth];
  sum_t                rem_d [Depth];
  logic [QuotBits-1:0] rest_d [Depth];
  logic [QuotBits-1:0] quot_d [Depth];

  always_comb begin
    rdy[Depth] = out_ready_i;
    for (int k = Depth - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  always_comb begin
    logic [SumBits:0] trial;
    logic             ge;
    vld_in[0]  = in_valid_i;
    rem_in[0]  = sum_t'(in_req_i.num >> HeadBits);
    den_in[0]  = in_req_i.den;
    rest_in[0] = {in_req_i.num[HeadBits-1:0], FracBits'(0)};
    quot_in[0] = '0;
    for (int k = 1; k < Depth; k++) begin
      vld_in[k]  = vld_q[k-1];
      rem_in[k]  = rem_q[k-1];
      den_in[k]  = den_q[k-1];
      rest_in[k] = rest_q[k-1];
      quot_in[k] = quot_q[k-1];
    end
    for (int k = 0; k < Depth; k++) begin
      trial     = {rem_in[k], rest_in[k][QuotBits-1]};
      ge        = trial >= {1'b0, den_in[k]};
      rem_d[k]  = ge ? SumBits'(trial - {1'b0, den_in[k]}) : SumBits'(trial);
      rest_d[k] = {rest_in[k][QuotBits-2:0], 1'b0};
      quot_d[k] = {quot_in[k][QuotBits-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Depth; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < Depth; k++) begin
        if (rdy[k]) vld_q[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Depth; k++) begin
      if (rdy[k] && vld_in[k]) begin
        rem_q[k]  <= rem_d[k];
        den_q[k]  <= den_in[k];
        rest_q[k] <= rest_d[k];
        quot_q[k] <= quot_d[k];
      end
    end
  end

  assign out_valid_o = vld_q[Depth-1];
  assign quot_o      = quot_q[Depth-1];

  // The ratio stays below 32, so the seeded remainder is already reduced.
  a_head_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> (sum_t'(in_req_i.num >> HeadBits) < in_req_i.den))
    else $error("divider seed remainder not below divisor");

  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Depth-1] |-> (rem_q[Depth-1] < den_q[Depth-1]))
    else $error("final remainder not below divisor");

  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (quot_o <= MaxRatio))
    else $error("contrast ratio above 21");

endmodule

/* design/srgb_contrast_ratio.sv */
// ---------------------------------------------------------------------------
// srgb_contrast_ratio: contrast ratio of two sRGB colors
// Decodes both colors to linear light, forms their luminance, and divides
// the offset first luminance by the offset second one in unsigned Q5.16.
// ---------------------------------------------------------------------------
//  channel   handshake             payload
//  input     in_valid_i/in_ready_o first_*_i, second_*_i (8-bit codes)
//  output    out_valid_o/out_ready_i contrast_ratio_o (21-bit Q5.16)
//
// One pair is taken per cycle while in_ready_o is high; each result passes
// through three decode/luminance stages and 21 divider stages, one
// quotient bit each. Reset clears only the stage valid bits. A stall at the
// output holds each stage with only full stages after it; empty stages still fill.
// ---------------------------------------------------------------------------
module srgb_contrast_ratio (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         first_red_i,
  input  logic [7:0]                         first_green_i,
  input  logic [7:0]                         first_blue_i,
  input  logic [7:0]                         second_red_i,
  input  logic [7:0]                         second_green_i,
  input  logic [7:0]                         second_blue_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [srgbcr_pkg::OutBits-1:0]     contrast_ratio_o
);
  import srgbcr_pkg::*;

  logic       req_valid;
  logic       req_ready;
  ratio_req_t req;

  srgbcr_luma u_luma (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .first_red_i    (first_red_i),
    .first_green_i  (first_green_i),
    .first_blue_i   (first_blue_i),
    .second_red_i   (second_red_i),
    .second_green_i (second_green_i),
    .second_blue_i  (second_blue_i),
    .out_valid_o    (req_valid),
    .out_ready_i    (req_ready),
    .out_req_o      (req)
  );

  srgbcr_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_req_i    (req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .quot_o      (contrast_ratio_o)
  );

endmodule
